// File: rtl/core/crtc_pkg.sv
// Shared types, constants and helpers for the line-step CRT controller.
// No dependencies; imported by every module under rtl/core.
package crtc_pkg;

    localparam logic [15:0] ADDR_MASK   = 16'hBF00;
    localparam logic [15:0] ADDR_SELECT = 16'hBC00;
    localparam logic [15:0] ADDR_DATA   = 16'hBD00;

    localparam logic [8:0] ROW_OFFSET  = 9'd32;
    localparam logic [8:0] LINE_LAST   = 9'd312;
    localparam logic [4:0] VSYNC_LEN   = 5'd16;
    localparam logic [7:0] X_CENTER    = 8'd50;
    localparam logic [9:0] X_LIMIT     = 10'd96;

    localparam logic [7:0] MASK_MODE   = 8'hF3;
    localparam logic [7:0] MASK_7BIT   = 8'h7F;
    localparam logic [7:0] MASK_5BIT   = 8'h1F;
    localparam logic [7:0] MASK_6BIT   = 8'h3F;
    localparam logic [7:0] MASK_FULL   = 8'hFF;

    localparam int          NUM_REGS   = 16;

    localparam logic [3:0] REG_H_TOTAL    = 4'd0;
    localparam logic [3:0] REG_H_DISP     = 4'd1;
    localparam logic [3:0] REG_HSYNC_POS  = 4'd2;
    localparam logic [3:0] REG_V_TOTAL    = 4'd4;
    localparam logic [3:0] REG_V_ADJUST   = 4'd5;
    localparam logic [3:0] REG_V_DISP     = 4'd6;
    localparam logic [3:0] REG_VSYNC_POS  = 4'd7;
    localparam logic [3:0] REG_MODE       = 4'd8;
    localparam logic [3:0] REG_MAX_RASTER = 4'd9;
    localparam logic [3:0] REG_CUR_START  = 4'd10;
    localparam logic [3:0] REG_CUR_END    = 4'd11;
    localparam logic [3:0] REG_START_HI   = 4'd12;
    localparam logic [3:0] REG_START_LO   = 4'd13;
    localparam logic [3:0] REG_CURSOR_HI  = 4'd14;

    typedef struct packed {
        logic [7:0] r1;
        logic [7:0] r4;
        logic [7:0] r6;
        logic [7:0] r7;
        logic [7:0] r9;
        logic [7:0] r12;
        logic [7:0] r13;
    } crtc_view_t;

    typedef struct packed {
        logic [8:0]  line_number;
        logic        vsync;
        logic        resync;
        logic        draw_valid;
        logic [8:0]  draw_row;
        logic        border;
        logic [16:0] video_address;
        logic [15:0] raster_bits;
    } crtc_line_t;

    function automatic logic [7:0] write_mask(input logic [3:0] idx);
        logic [7:0] m;
        unique case (idx)
            REG_MODE:                                   m = MASK_MODE;
            REG_V_TOTAL, REG_V_DISP,
            REG_VSYNC_POS, REG_CUR_START:               m = MASK_7BIT;
            REG_V_ADJUST, REG_MAX_RASTER, REG_CUR_END:  m = MASK_5BIT;
            REG_START_HI, REG_CURSOR_HI:                m = MASK_6BIT;
            default:                                    m = MASK_FULL;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/core/crtc_regs.sv
// Register file: select latch, masked data writes and horizontal edge math.
// Depends on crtc_pkg.
module crtc_regs
    import crtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [15:0] bus_address,
    input  logic [7:0]  bus_data,
    output crtc_view_t  view,
    output logic [6:0]  x_start,
    output logic [6:0]  x_end
);

    logic [7:0] regs_reg [NUM_REGS];
    logic [4:0] sel_reg;
    logic [4:0] sel_next;
    logic       sel_hit;
    logic       data_hit;
    logic       data_wr;
    logic [7:0] data_masked;
    logic [7:0] r1_post;
    logic [7:0] r2_post;
    logic [7:0] x_diff;
    logic [9:0] x_sum;

    assign sel_hit     = wr_en && ((bus_address & ADDR_MASK) == ADDR_SELECT);
    assign data_hit    = wr_en && ((bus_address & ADDR_MASK) == ADDR_DATA);
    assign data_wr     = data_hit && !sel_reg[4];
    assign data_masked = bus_data & write_mask(sel_reg[3:0]);
    assign sel_next    = sel_hit ? bus_data[4:0] : sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= '0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= (i == 0) ? 8'h00 : 8'hFF;
            end
        end
        else
        begin
            sel_reg <= sel_next;
            if (data_wr)
            begin
                regs_reg[sel_reg[3:0]] <= data_masked;
            end
        end
    end

    assign view.r1  = regs_reg[REG_H_DISP];
    assign view.r4  = regs_reg[REG_V_TOTAL];
    assign view.r6  = regs_reg[REG_V_DISP];
    assign view.r7  = regs_reg[REG_VSYNC_POS];
    assign view.r9  = regs_reg[REG_MAX_RASTER];
    assign view.r12 = regs_reg[REG_START_HI];
    assign view.r13 = regs_reg[REG_START_LO];

    // edges reflect the register values after this beat's write
    assign r1_post = (data_wr && sel_reg[3:0] == REG_H_DISP)    ? data_masked
                                                                 : regs_reg[REG_H_DISP];
    assign r2_post = (data_wr && sel_reg[3:0] == REG_HSYNC_POS) ? data_masked
                                                                 : regs_reg[REG_HSYNC_POS];

    always_comb
    begin
        x_diff  = X_CENTER - r2_post;
        x_start = (r2_post < X_CENTER) ? {x_diff[5:0], 1'b0} : 7'd0;
        x_sum   = {3'b000, x_start} + {1'b0, r1_post, 1'b0};
        x_end   = (x_sum > X_LIMIT) ? X_LIMIT[6:0] : x_sum[6:0];
    end

endmodule

// File: rtl/core/crtc_raster.sv
// Raster, character-row, address and vertical sync counters for one line step.
// Depends on crtc_pkg; register values come from crtc_regs.
module crtc_raster
    import crtc_pkg::*;
#(
    parameter int VISIBLE_LINES = 272
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  crtc_view_t view,
    output crtc_line_t line
);

    logic [4:0]  vcount_reg;
    logic [4:0]  vcount_next;
    logic        vsync_reg;
    logic        vsync_next;
    logic        resync_reg;
    logic        resync_next;
    logic [8:0]  scan_reg;
    logic [8:0]  scan_next;
    logic [4:0]  raster_reg;
    logic [4:0]  raster_next;
    logic [6:0]  row_reg;
    logic [6:0]  row_next;
    logic [15:0] addr_reg;
    logic [15:0] addr_next;
    logic [8:0]  y;
    logic        in_disp;

    always_comb
    begin
        vcount_next = vcount_reg;
        vsync_next  = vsync_reg;
        resync_next = resync_reg;
        scan_next   = scan_reg;
        raster_next = raster_reg;
        row_next    = row_reg;
        addr_next   = addr_reg;
        y           = '0;
        in_disp     = 1'b0;

        line.draw_valid    = 1'b0;
        line.draw_row      = '0;
        line.border        = 1'b0;
        line.video_address = '0;
        line.raster_bits   = '0;

        if (tick)
        begin
            if (vcount_reg != 5'd0)
            begin
                vcount_next = vcount_reg - 5'd1;
                if (vcount_reg == 5'd1)
                begin
                    vsync_next = 1'b0;
                end
            end

            scan_next = scan_reg + 9'd1;

            if ({3'b000, raster_reg} == view.r9)
            begin
                raster_next = '0;
                row_next    = row_reg + 7'd1;
                addr_next   = addr_reg + {8'h00, view.r1};
            end
            else
            begin
                raster_next = raster_reg + 5'd1;
            end

            if ({2'b00, row_next} == ({1'b0, view.r4} + 9'd1))
            begin
                raster_next = '0;
                row_next    = '0;
                addr_next   = {view.r12, view.r13};
            end

            y = scan_next - ROW_OFFSET;

            if ({1'b0, row_next} == view.r7 && raster_next == 5'd0)
            begin
                scan_next   = '0;
                vcount_next = VSYNC_LEN;
                vsync_next  = 1'b1;
                resync_next = 1'b1;
            end
            else if (scan_next >= ROW_OFFSET && y < 9'(VISIBLE_LINES))
            begin
                in_disp            = {1'b0, row_next} < view.r6;
                line.draw_valid    = 1'b1;
                line.draw_row      = y;
                line.border        = !in_disp;
                line.video_address = in_disp ? {addr_next, 1'b0} : 17'd0;
                line.raster_bits   = {raster_next, 11'd0} | {addr_next[13:12], 14'd0};
            end
            else if (scan_next > LINE_LAST)
            begin
                scan_next   = '0;
                resync_next = 1'b0;
            end
        end

        line.line_number = scan_next;
        line.vsync       = vsync_next;
        line.resync      = resync_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VSYNC_LEN;
            vsync_reg  <= 1'b0;
            resync_reg <= 1'b0;
            scan_reg   <= '0;
            raster_reg <= '0;
            row_reg    <= '0;
            addr_reg   <= '0;
        end
        else
        begin
            vcount_reg <= vcount_next;
            vsync_reg  <= vsync_next;
            resync_reg <= resync_next;
            scan_reg   <= scan_next;
            raster_reg <= raster_next;
            row_reg    <= row_next;
            addr_reg   <= addr_next;
        end
    end

`ifndef ASSERT_OFF
    a_vsync_counts: assert property (@(posedge clk) disable iff (!rst_n)
        vsync_reg |-> (vcount_reg != 5'd0))
        else $error("vsync active with countdown at zero");

    a_vcount_range: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VSYNC_LEN)
        else $error("vsync countdown above sync length");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= LINE_LAST)
        else $error("scan line past frame end");
`endif

endmodule

// File: rtl/core/crt_controller_line_step.sv
// Top level of the line-step CRT controller: input and result registers.
// Depends on crtc_pkg, crtc_regs and crtc_raster.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one beat per item: kind 0 is
//   a bus write (bus_address masked with 0xBF00; 0xBC00 selects a register,
//   0xBD00 writes it), kind 1 is one scanline tick.
//   Output channel (out_valid / out_stall) returns exactly one result beat
//   per input beat, in order, showing the state after that item.
//   The input register loads at the accepting edge; the result register
//   loads from it when it is free (not held by out_stall). Throughput: one
//   item per cycle while out_stall is low; the counters and the register
//   file update from the input register at the edge that loads the result.
//   When out_stall holds a result, at most one more item is taken into the
//   input register; after that in_stall rises until the result is taken.
//   Reset (rst_n low, asynchronous) empties both stages, loads register 0
//   with 0 and all others with 0xFF, clears the counters and sets the sync
//   countdown to 16. No clearing pass is needed.
//   VISIBLE_LINES (1 to 280) sets how many lines from line 32 on request drawing.
module crt_controller_line_step
    import crtc_pkg::*;
#(
    parameter int VISIBLE_LINES = 272
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] bus_address,
    input  logic [7:0]  bus_data,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [8:0]  line_number,
    output logic        vsync,
    output logic        resync,
    output logic        draw_valid,
    output logic [8:0]  draw_row,
    output logic        border,
    output logic [16:0] video_address,
    output logic [15:0] raster_bits,
    output logic [6:0]  x_start,
    output logic [6:0]  x_end
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_kind_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0]  s1_data_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    crtc_line_t  out_line_reg;
    logic [6:0]  out_xs_reg;
    logic [6:0]  out_xe_reg;

    logic        out_free;
    logic        s1_move;
    logic        in_take;

    crtc_view_t  view;
    crtc_line_t  line;
    logic [6:0]  xs;
    logic [6:0]  xe;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    crtc_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (s1_move && !s1_kind_reg),
        .bus_address (s1_addr_reg),
        .bus_data    (s1_data_reg),
        .view        (view),
        .x_start     (xs),
        .x_end       (xe)
    );

    crtc_raster #(
        .VISIBLE_LINES (VISIBLE_LINES)
    ) u_raster (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (s1_move && s1_kind_reg),
        .view  (view),
        .line  (line)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_kind_reg <= kind;
            s1_addr_reg <= bus_address;
            s1_data_reg <= bus_data;
        end
        if (s1_move)
        begin
            out_line_reg <= line;
            out_xs_reg   <= xs;
            out_xe_reg   <= xe;
        end
    end

    assign out_valid     = out_valid_reg;
    assign line_number   = out_line_reg.line_number;
    assign vsync         = out_line_reg.vsync;
    assign resync        = out_line_reg.resync;
    assign draw_valid    = out_line_reg.draw_valid;
    assign draw_row      = out_line_reg.draw_row;
    assign border        = out_line_reg.border;
    assign video_address = out_line_reg.video_address;
    assign raster_bits   = out_line_reg.raster_bits;
    assign x_start       = out_xs_reg;
    assign x_end         = out_xe_reg;

`ifndef ASSERT_OFF
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && s1_valid_reg))
        else $error("input stalled without a blocked result");

    a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("moved beat did not reach the result register");

    a_draw_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_line_reg.draw_valid) |->
            (out_line_reg.line_number >= ROW_OFFSET &&
             out_line_reg.draw_row == out_line_reg.line_number - ROW_OFFSET))
        else $error("draw row does not match line number");
`endif

endmodule

// File: verif/tb.sv
// Self-checking bench for crt_controller_line_step: bus writes and scanline ticks are
// driven with random idle and stall, and every result beat is checked against a predictor.
// Depends on crtc_pkg and the RTL under rtl/core.
module tb;
    import crtc_pkg::*;

    localparam int VISIBLE_LINES = 272;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int ITEM_TARGET   = 1300;
    localparam int PRINT_CAP     = 50;

    typedef struct {
        bit        is_tick;
        bit [15:0] addr;
        bit [7:0]  data;
    } bus_item_t;

    typedef struct packed {
        logic [8:0]  line_number;
        logic        vsync;
        logic        resync;
        logic        draw_valid;
        logic [8:0]  draw_row;
        logic        border;
        logic [16:0] video_address;
        logic [15:0] raster_bits;
        logic [6:0]  x_start;
        logic [6:0]  x_end;
    } scan_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [15:0] bus_address = '0;
    logic [7:0]  bus_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [8:0]  line_number;
    logic        vsync;
    logic        resync;
    logic        draw_valid;
    logic [8:0]  draw_row;
    logic        border;
    logic [16:0] video_address;
    logic [15:0] raster_bits;
    logic [6:0]  x_start;
    logic [6:0]  x_end;

    crt_controller_line_step #(.VISIBLE_LINES(VISIBLE_LINES)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .bus_address(bus_address), .bus_data(bus_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .line_number(line_number), .vsync(vsync), .resync(resync),
        .draw_valid(draw_valid), .draw_row(draw_row), .border(border),
        .video_address(video_address), .raster_bits(raster_bits),
        .x_start(x_start), .x_end(x_end)
    );

    // predictor state
    bit [7:0]  crtc_reg [NUM_REGS];
    bit [4:0]  reg_sel;
    bit [4:0]  vsync_left;
    bit [6:0]  char_row;
    bit [4:0]  raster;
    bit [8:0]  line_cnt;
    bit [15:0] mem_addr;
    bit        vsync_on;
    bit        resync_on;

    bus_item_t    pending [$];
    scan_result_t expected_lines [$];

    int  mismatches = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_ticks = 0;
    int  n_writes = 0;
    int  n_draws = 0;
    int  n_syncs = 0;
    int  n_wraps = 0;
    int  cycles = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  send_quiet = 1'b0;
    bit  recv_quiet = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0h, want %0h",
                                   n_results, name, got, want));
    endtask

    function automatic int draw_idle(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < NUM_REGS; i++)
            crtc_reg[i] = 8'hFF;
        crtc_reg[REG_H_TOTAL] = 8'h00;
        reg_sel    = '0;
        vsync_left = VSYNC_LEN;
        char_row   = '0;
        raster     = '0;
        line_cnt   = '0;
        mem_addr   = '0;
        vsync_on   = 1'b0;
        resync_on  = 1'b0;
    endfunction

    function automatic void predict_line(input logic is_tick, input logic [15:0] addr,
                                         input logic [7:0] data);
        scan_result_t r;
        bit [15:0]    dec;
        bit [7:0]     v;
        int           xs;
        int           xe;
        int           ln;
        r = '0;
        if (!is_tick) begin
            n_writes++;
            dec = addr & ADDR_MASK;
            if (dec == ADDR_SELECT)
                reg_sel = data[4:0];
            else if (dec == ADDR_DATA && reg_sel < NUM_REGS) begin
                case (reg_sel[3:0])
                    REG_MODE:                                   v = data & MASK_MODE;
                    REG_V_TOTAL, REG_V_DISP,
                    REG_VSYNC_POS, REG_CUR_START:               v = data & MASK_7BIT;
                    REG_V_ADJUST, REG_MAX_RASTER, REG_CUR_END:  v = data & MASK_5BIT;
                    REG_START_HI, REG_CURSOR_HI:                v = data & MASK_6BIT;
                    default:                                    v = data;
                endcase
                crtc_reg[reg_sel[3:0]] = v;
            end
        end else begin
            n_ticks++;
            if (vsync_left != 0) begin
                vsync_left--;
                if (vsync_left == 0)
                    vsync_on = 1'b0;
            end
            line_cnt = line_cnt + 9'd1;
            if ({3'b000, raster} == crtc_reg[REG_MAX_RASTER]) begin
                raster   = '0;
                char_row = char_row + 7'd1;
                mem_addr = mem_addr + crtc_reg[REG_H_DISP];
            end else begin
                raster = raster + 5'd1;
            end
            if (int'(char_row) == int'(crtc_reg[REG_V_TOTAL]) + 1) begin
                raster   = '0;
                char_row = '0;
                mem_addr = {crtc_reg[REG_START_HI], crtc_reg[REG_START_LO]};
            end
            ln = line_cnt;
            if ({1'b0, char_row} == crtc_reg[REG_VSYNC_POS] && raster == 0) begin
                // sync start: counters restart, no draw on this line
                line_cnt   = '0;
                vsync_left = VSYNC_LEN;
                vsync_on   = 1'b1;
                resync_on  = 1'b1;
                n_syncs++;
            end else if (ln >= int'(ROW_OFFSET) && ln - int'(ROW_OFFSET) < VISIBLE_LINES) begin
                n_draws++;
                r.draw_valid = 1'b1;
                r.draw_row   = line_cnt - ROW_OFFSET;
                r.border     = ({1'b0, char_row} >= crtc_reg[REG_V_DISP]);
                r.video_address = r.border ? 17'd0 : {mem_addr, 1'b0};
                r.raster_bits   = {raster, 11'd0} | {mem_addr[13:12], 14'd0};
            end else if (line_cnt > LINE_LAST) begin
                line_cnt  = '0;
                resync_on = 1'b0;
                n_wraps++;
            end
        end
        xs = (int'(X_CENTER) - int'(crtc_reg[REG_HSYNC_POS])) * 2;
        if (xs < 0)
            xs = 0;
        xe = xs + int'(crtc_reg[REG_H_DISP]) * 2;
        if (xe > int'(X_LIMIT))
            xe = int'(X_LIMIT);
        r.line_number = line_cnt;
        r.vsync       = vsync_on;
        r.resync      = resync_on;
        r.x_start     = 7'(xs);
        r.x_end       = 7'(xe);
        expected_lines.push_back(r);
    endfunction

    function automatic void push_item(input bit is_tick, input bit [15:0] addr,
                                      input bit [7:0] data);
        bus_item_t it;
        it.is_tick = is_tick;
        it.addr    = addr;
        it.data    = data;
        pending.push_back(it);
    endfunction

    function automatic void push_tick();
        push_item(1'b1, 16'($urandom), 8'($urandom));
    endfunction

    // select then data write, with the don't-care address bits randomized
    function automatic void push_reg(input bit [3:0] idx, input bit [7:0] val);
        bit [7:0] d;
        d = 8'($urandom);
        d[4:0] = {1'b0, idx};
        push_item(1'b0, ADDR_SELECT | (16'($urandom) & ~ADDR_MASK), d);
        push_item(1'b0, ADDR_DATA | (16'($urandom) & ~ADDR_MASK), val);
    endfunction

    function automatic bit [7:0] mostly_small(input int hi);
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return 8'($urandom_range(0, hi));
    endfunction

    function automatic void push_noise();
        bit [15:0] a;
        case ($urandom_range(0, 2))
            0:       a = 16'($urandom);
            1:       a = ADDR_SELECT | (16'($urandom) & ~ADDR_MASK);
            default: a = ADDR_DATA | (16'($urandom) & ~ADDR_MASK);
        endcase
        push_item(1'($urandom), a, 8'($urandom));
    endfunction

    function automatic void build_stimulus();
        int  pick;
        int  n_ticks_burst;
        bit  long_frame;
        // directed
        push_tick();
        push_item(1'b0, 16'hBC00, 8'h01);
        push_item(1'b0, 16'hFDFF, 8'hFF);
        push_reg(REG_HSYNC_POS, 8'h00);
        push_reg(REG_MODE, 8'hFF);
        push_item(1'b0, 16'hFC00, 8'h14);
        push_item(1'b0, 16'hBD00, 8'h55);
        push_item(1'b0, 16'hBCFF, 8'hFF);
        push_item(1'b0, 16'hBD00, 8'hAA);
        push_item(1'b0, 16'h0000, 8'hFF);
        push_item(1'b0, 16'hFFFF, 8'h00);
        push_item(1'b0, 16'hBE00, 8'hAA);
        push_item(1'b0, 16'h3D00, 8'h55);
        push_reg(REG_HSYNC_POS, 8'hFF);
        push_reg(REG_MAX_RASTER, 8'h00);
        push_reg(REG_VSYNC_POS, 8'h01);
        push_item(1'b1, 16'hFFFF, 8'hFF);
        push_item(1'b1, 16'h0000, 8'h00);

        // random: register programs followed by tick bursts, some noise
        while (pending.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(5, 20))
                    push_noise();
            end else begin
                long_frame = (pick == 1);
                if (long_frame || $urandom_range(0, 1))
                    push_reg(REG_MAX_RASTER, mostly_small(7));
                if (long_frame || $urandom_range(0, 1))
                    push_reg(REG_V_TOTAL, long_frame ? 8'($urandom_range(0, 60))
                                                     : mostly_small(45));
                if (long_frame)
                    push_reg(REG_VSYNC_POS, 8'h7F);
                else if ($urandom_range(0, 1))
                    push_reg(REG_VSYNC_POS, mostly_small(45));
                if ($urandom_range(0, 1))
                    push_reg(REG_V_DISP, mostly_small(45));
                if ($urandom_range(0, 1))
                    push_reg(REG_H_DISP, 8'($urandom));
                if ($urandom_range(0, 1))
                    push_reg(REG_HSYNC_POS, mostly_small(60));
                if ($urandom_range(0, 2) == 0)
                    push_reg(REG_START_HI, 8'($urandom));
                if ($urandom_range(0, 2) == 0)
                    push_reg(REG_START_LO, 8'($urandom));
                repeat ($urandom_range(1, 2))
                    push_reg(4'($urandom_range(0, NUM_REGS - 1)), 8'($urandom));
                n_ticks_burst = long_frame ? $urandom_range(330, 360) : $urandom_range(20, 150);
                repeat (n_ticks_burst) begin
                    if ($urandom_range(0, 29) == 0)
                        push_noise();
                    push_tick();
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : driver
        bus_item_t it;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            kind        <= 1'b0;
            bus_address <= '0;
            bus_data    <= '0;
            gap_left    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_line(kind, bus_address, bus_data);
                n_items++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending.size() != 0)
                begin
                    it = pending.pop_front();
                    kind        <= it.is_tick;
                    bus_address <= it.addr;
                    bus_data    <= it.data;
                    in_valid    <= 1'b1;
                    gap_left    <= draw_idle(send_quiet);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        scan_result_t want;
        int           nh;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            nh = stall_left;
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_lines.size() == 0)
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           n_results));
                else
                begin
                    want = expected_lines.pop_front();
                    compare_field("line_number", line_number, want.line_number);
                    compare_field("vsync", vsync, want.vsync);
                    compare_field("resync", resync, want.resync);
                    compare_field("draw_valid", draw_valid, want.draw_valid);
                    compare_field("draw_row", draw_row, want.draw_row);
                    compare_field("border", border, want.border);
                    compare_field("video_address", video_address, want.video_address);
                    compare_field("raster_bits", raster_bits, want.raster_bits);
                    compare_field("x_start", x_start, want.x_start);
                    compare_field("x_end", x_end, want.x_end);
                end
                nh = draw_idle(recv_quiet);
            end
            else if (nh != 0)
            begin
                nh--;
            end
            stall_left <= nh;
            out_stall  <= (nh != 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_lines.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        reset_model();
        build_stimulus();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending.size() != 0 || in_valid || expected_lines.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (expected_lines.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_lines.size()));
        $display("Ran %0d beats: %0d scanline ticks, %0d bus writes, %0d results checked",
                 n_items, n_ticks, n_writes, n_results);
        $display("Drawn lines %0d, sync starts %0d, frame wraps %0d, mismatches %0d",
                 n_draws, n_syncs, n_wraps, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
